FILE: rtl/swsl_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// swsl_pkg: shared types and constants for the stop-and-wait supervision link
// Holds the channel payload structs, operation and result codes, register
// indexes and the command format passed from the front end to the back end.
// ----------------------------------------------------------------------------
package swsl_pkg;

    // Number of bytes in one supervision frame.
    localparam int FRAME_LEN = 5;
    localparam int BEAT_W    = $clog2(FRAME_LEN);

    // Default depth of the command queue between front and back end.
    localparam int CMD_DEPTH_DEFAULT = 4;

    // Reset values of the configuration registers.
    localparam logic [7:0]  FLAG_RESET    = 8'd126;
    localparam logic [7:0]  ADDR_RESET    = 8'd3;
    localparam logic [3:0]  MAXATT_RESET  = 4'd3;
    localparam logic [15:0] TIMEOUT_RESET = 16'd3;

    // Input operation codes.
    typedef enum logic [1:0] {
        OP_START  = 2'd0,
        OP_RXBYTE = 2'd1,
        OP_TICK   = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    // Result kinds.
    typedef enum logic [1:0] {
        KIND_TX   = 2'd0,
        KIND_OK   = 2'd1,
        KIND_FAIL = 2'd2
    } t_kind;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_FLAG    = 2'd0,
        CFG_ADDR    = 2'd1,
        CFG_MAXATT  = 2'd2,
        CFG_TIMEOUT = 2'd3
    } t_cfg_idx;

    // One input transaction.
    typedef struct packed {
        logic [1:0] op;
        logic [7:0] data_byte;
        logic [7:0] control_to_send;
        logic [7:0] control_to_expect;
    } t_in_item;

    // One result transaction.
    typedef struct packed {
        t_kind      kind;
        logic [7:0] tx_byte;
        logic       last;
    } t_out_item;

    // Command from front end to back end: a frame to send or a report.
    typedef struct packed {
        t_kind      kind;
        logic [7:0] flag;
        logic [7:0] addr;
        logic [7:0] ctrl;
    } t_cmd;

endpackage : swsl_pkg
`default_nettype wire

FILE: rtl/swsl_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// swsl_front: item classification and link protocol state
// Accepts input transactions, runs the answer-frame recognizer and the
// retry timer, holds the configuration registers and queues commands.
// ----------------------------------------------------------------------------
module swsl_front
    import swsl_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // Input channel
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire t_in_item   i_in_item,
    // Configuration write channel
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [1:0] i_cfg_index,
    input  wire logic [15:0] i_cfg_data,
    // Command queue write side
    input  wire logic       i_q_full,
    output logic            o_q_push,
    output t_cmd            o_q_cmd
);

    // One-hot recognizer positions.
    typedef enum logic [4:0] {
        RX_FLAG  = 5'b00001,
        RX_ADDR  = 5'b00010,
        RX_CTRL  = 5'b00100,
        RX_CHECK = 5'b01000,
        RX_CLOSE = 5'b10000
    } t_rx_state;

    logic [7:0]  r_flag;
    logic [7:0]  r_addr;
    logic [3:0]  r_max_att;
    logic [15:0] r_timeout;

    logic        r_active,   n_active;
    t_rx_state   r_rx_state, n_rx_state;
    logic [3:0]  r_attempts, n_attempts;
    logic [15:0] r_ticks,    n_ticks;
    logic [7:0]  r_sent_ctrl, n_sent_ctrl;
    logic [7:0]  r_exp_ctrl,  n_exp_ctrl;

    logic        accept;
    logic [15:0] reload;
    logic [3:0]  att_inc;
    logic [7:0]  b;

    assign o_in_stall  = i_q_full;
    assign o_cfg_ready = 1'b1;
    assign accept      = i_in_valid & ~i_q_full;
    assign reload      = (r_timeout == 16'd0) ? 16'd1 : r_timeout;
    assign att_inc     = (r_attempts < 4'd15) ? r_attempts + 4'd1 : r_attempts;
    assign b           = i_in_item.data_byte;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flag    <= FLAG_RESET;
            r_addr    <= ADDR_RESET;
            r_max_att <= MAXATT_RESET;
            r_timeout <= TIMEOUT_RESET;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_FLAG:    r_flag    <= i_cfg_data[7:0];
                CFG_ADDR:    r_addr    <= i_cfg_data[7:0];
                CFG_MAXATT:  r_max_att <= i_cfg_data[3:0];
                CFG_TIMEOUT: r_timeout <= i_cfg_data;
                default:     r_flag    <= r_flag;
            endcase
        end
    end

    // Next-state and command generation for one accepted transaction.
    always_comb begin
        n_active    = r_active;
        n_rx_state  = r_rx_state;
        n_attempts  = r_attempts;
        n_ticks     = r_ticks;
        n_sent_ctrl = r_sent_ctrl;
        n_exp_ctrl  = r_exp_ctrl;
        o_q_push    = 1'b0;
        o_q_cmd     = '{kind: KIND_TX, flag: r_flag, addr: r_addr, ctrl: r_sent_ctrl};

        if (accept) begin
            unique case (t_op'(i_in_item.op))
                OP_START: begin
                    n_sent_ctrl  = i_in_item.control_to_send;
                    n_exp_ctrl   = i_in_item.control_to_expect;
                    n_attempts   = 4'd0;
                    n_active     = 1'b1;
                    n_rx_state   = RX_FLAG;
                    n_ticks      = reload;
                    o_q_push     = 1'b1;
                    o_q_cmd.ctrl = i_in_item.control_to_send;
                end
                OP_RXBYTE: begin
                    if (r_active) begin
                        unique case (r_rx_state)
                            RX_FLAG: begin
                                if (b == r_flag) n_rx_state = RX_ADDR;
                            end
                            RX_ADDR: begin
                                if (b == r_addr)      n_rx_state = RX_CTRL;
                                else if (b == r_flag) n_rx_state = RX_ADDR;
                                else                  n_rx_state = RX_FLAG;
                            end
                            RX_CTRL: begin
                                if (b == r_exp_ctrl)  n_rx_state = RX_CHECK;
                                else if (b == r_flag) n_rx_state = RX_ADDR;
                                else                  n_rx_state = RX_FLAG;
                            end
                            RX_CHECK: begin
                                if (b == (r_addr ^ r_exp_ctrl)) n_rx_state = RX_CLOSE;
                                else                            n_rx_state = RX_FLAG;
                            end
                            RX_CLOSE: begin
                                n_rx_state = RX_FLAG;
                                if (b == r_flag) begin
                                    n_active     = 1'b0;
                                    o_q_push     = 1'b1;
                                    o_q_cmd.kind = KIND_OK;
                                end
                            end
                            default: n_rx_state = RX_FLAG;
                        endcase
                    end
                end
                OP_TICK: begin
                    if (r_active) begin
                        if (r_ticks > 16'd1) begin
                            n_ticks = r_ticks - 16'd1;
                        end else begin
                            n_attempts = att_inc;
                            n_rx_state = RX_FLAG;
                            o_q_push   = 1'b1;
                            if (att_inc >= r_max_att) begin
                                // Out of attempts: report failure and go idle.
                                n_ticks      = 16'd0;
                                n_active     = 1'b0;
                                o_q_cmd.kind = KIND_FAIL;
                            end else begin
                                // Timeout: resend the frame and rearm the timer.
                                n_ticks = reload;
                            end
                        end
                    end
                end
                default: begin
                    n_active = r_active;
                end
            endcase
        end
    end

    // Protocol state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_rx_state  <= RX_FLAG;
            r_attempts  <= 4'd0;
            r_ticks     <= 16'd0;
            r_sent_ctrl <= 8'd0;
            r_exp_ctrl  <= 8'd0;
        end else begin
            r_active    <= n_active;
            r_rx_state  <= n_rx_state;
            r_attempts  <= n_attempts;
            r_ticks     <= n_ticks;
            r_sent_ctrl <= n_sent_ctrl;
            r_exp_ctrl  <= n_exp_ctrl;
        end
    end

endmodule : swsl_front
`default_nettype wire

FILE: rtl/swsl_cmd_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// swsl_cmd_fifo: command queue between front and back end
// A small first-in first-out buffer of frame and report commands.
// ----------------------------------------------------------------------------
module swsl_cmd_fifo
    import swsl_pkg::*;
#(
    parameter int DEPTH = CMD_DEPTH_DEFAULT
)
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    output logic      o_full,
    input  wire logic i_pop,
    output logic      o_empty,
    output t_cmd      o_cmd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == CNT_FULL);
    assign o_empty = (r_count == '0);
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & ~o_empty;
    assign o_cmd   = r_mem[r_rd_ptr];

    // Storage write.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule : swsl_cmd_fifo
`default_nettype wire

FILE: rtl/swsl_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// swsl_back: result generator
// Expands frame commands into five transmit bytes and reports into single
// results, one per unstalled cycle, through a registered output stage.
// ----------------------------------------------------------------------------
module swsl_back
    import swsl_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    // Command queue read side
    input  wire logic  i_q_empty,
    input  wire t_cmd  i_q_cmd,
    output logic       o_q_pop,
    // Output channel
    output logic       o_out_valid,
    input  wire logic  i_out_stall,
    output t_out_item  o_out_item
);

    localparam logic [BEAT_W-1:0] BEAT_LAST = BEAT_W'(FRAME_LEN - 1);

    logic              r_busy;
    t_cmd              r_cmd;
    logic [BEAT_W-1:0] r_beat;
    logic              r_out_valid;
    t_out_item         r_out_item;

    logic              advance;
    logic              have_src;
    t_cmd              src_cmd;
    logic [BEAT_W-1:0] src_beat;
    t_out_item         beat_item;

    assign advance  = ~r_out_valid | ~i_out_stall;
    assign have_src = r_busy | ~i_q_empty;
    assign src_cmd  = r_busy ? r_cmd : i_q_cmd;
    assign src_beat = r_busy ? r_beat : '0;
    assign o_q_pop  = advance & ~r_busy & ~i_q_empty;

    // Build the result for the current beat of the current command.
    always_comb begin
        beat_item = '{kind: src_cmd.kind, tx_byte: 8'd0, last: 1'b1};
        if (src_cmd.kind == KIND_TX) begin
            beat_item.last = (src_beat == BEAT_LAST);
            case (src_beat)
                BEAT_W'(0): beat_item.tx_byte = src_cmd.flag;
                BEAT_W'(1): beat_item.tx_byte = src_cmd.addr;
                BEAT_W'(2): beat_item.tx_byte = src_cmd.ctrl;
                BEAT_W'(3): beat_item.tx_byte = src_cmd.addr ^ src_cmd.ctrl;
                default:    beat_item.tx_byte = src_cmd.flag;
            endcase
        end
    end

    // Command hold register and beat counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_beat <= '0;
        end else if (advance && have_src) begin
            if (beat_item.last) begin
                r_busy <= 1'b0;
                r_beat <= '0;
            end else begin
                r_busy <= 1'b1;
                r_beat <= src_beat + BEAT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && !r_busy) begin
            r_cmd <= i_q_cmd;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= have_src;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_item <= beat_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule : swsl_back
`default_nettype wire

FILE: rtl/stop_and_wait_supervision_link.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stop_and_wait_supervision_link: supervision frame exchange with retries
// Input transactions are start, received byte and time tick events; each
// is taken when i_in_valid is high and o_in_stall is low. A start sends a
// five-byte frame (flag, address, control, check, flag), then received
// bytes are matched against the expected answer frame and ticks count down
// the per-attempt timeout. A timeout resends the frame until the attempt
// limit, then a failure result is given; a matched answer gives success.
// Results leave on the output channel when o_out_valid is high and
// i_out_stall is low; the last result of each input has last set.
// An accepted input's command is written to the command queue, and its first
// result is then registered at the output. One input is taken per cycle while
// the four-entry command queue has room; a frame leaves as five output bytes,
// so a stream of frame-producing inputs settles at the output byte rate.
// A stalled receiver holds the output register, the queue fills, and then
// o_in_stall rises. Configuration writes are always ready. Reset clears
// the exchange state, the queue and the output and loads register defaults.
// ----------------------------------------------------------------------------
module stop_and_wait_supervision_link
    import swsl_pkg::*;
#(
    parameter int CMD_DEPTH = CMD_DEPTH_DEFAULT
)
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Input channel
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire t_in_item    i_in_item,
    // Output channel
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output t_out_item        o_out_item,
    // Configuration write channel
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);

    logic q_push;
    logic q_full;
    logic q_pop;
    logic q_empty;
    t_cmd q_wr_cmd;
    t_cmd q_rd_cmd;

    // Front end: protocol state and command issue.
    swsl_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_q_full    (q_full),
        .o_q_push    (q_push),
        .o_q_cmd     (q_wr_cmd)
    );

    // Command queue.
    swsl_cmd_fifo #(
        .DEPTH (CMD_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_wr_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_cmd   (q_rd_cmd)
    );

    // Back end: result generation.
    swsl_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_q_cmd     (q_rd_cmd),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule : stop_and_wait_supervision_link
`default_nettype wire

FILE: test/stop_and_wait_supervision_link_test.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stop_and_wait_supervision_link_test: self-checking bench for the link block
// Drives start, received byte and tick events into the block. A behavioral
// copy of the exchange logic predicts every frame byte and report. Each result
// transaction is checked in order against that prediction. Idle gaps and output
// stalls come in random bursts, and configuration changes happen between phases.
// ----------------------------------------------------------------------------
module stop_and_wait_supervision_link_test;
    import swsl_pkg::*;

    // Recognizer positions of the answer frame matcher.
    localparam logic [2:0] POS_OPEN  = 3'd0;
    localparam logic [2:0] POS_ADDR  = 3'd1;
    localparam logic [2:0] POS_CTRL  = 3'd2;
    localparam logic [2:0] POS_CHECK = 3'd3;
    localparam logic [2:0] POS_CLOSE = 3'd4;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    t_in_item    i_in_item;
    logic        o_out_valid;
    logic        i_out_stall;
    t_out_item   o_out_item;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [15:0] i_cfg_data;

    // Register copies and exchange state of the predictor.
    logic [7:0]  cfg_flag;
    logic [7:0]  cfg_addr;
    logic [3:0]  cfg_max_att;
    logic [15:0] cfg_timeout;
    logic        link_active;
    logic [2:0]  match_pos;
    logic [3:0]  attempt_count;
    logic [15:0] ticks_left;
    logic [7:0]  sent_ctrl;
    logic [7:0]  awaited_ctrl;

    t_out_item   expected_results[$];
    t_out_item   oldest_result;
    int          error_count;
    int          event_count;
    int          stall_left;
    int          gap_odds;
    bit          in_gaps_on;
    bit          out_stalls_on;

    stop_and_wait_supervision_link u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog against a hung handshake.
    initial begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // Appends one expected result transaction.
    function automatic void queue_result(t_kind kind, logic [7:0] tx_byte, logic last);
        t_out_item r;
        r.kind    = kind;
        r.tx_byte = tx_byte;
        r.last    = last;
        expected_results.push_back(r);
    endfunction

    // A supervision frame goes out and the recognizer and timer restart.
    function automatic void queue_frame();
        queue_result(KIND_TX, cfg_flag, 1'b0);
        queue_result(KIND_TX, cfg_addr, 1'b0);
        queue_result(KIND_TX, sent_ctrl, 1'b0);
        queue_result(KIND_TX, cfg_addr ^ sent_ctrl, 1'b0);
        queue_result(KIND_TX, cfg_flag, 1'b1);
        match_pos  = POS_OPEN;
        ticks_left = (cfg_timeout == 16'd0) ? 16'd1 : cfg_timeout;
    endfunction

    // Advances the exchange state for one accepted event. Returns 0 when the
    // block simply ignores the event.
    function automatic bit predict_link(t_in_item item);
        logic [7:0] b;
        b = item.data_byte;
        if (item.op == OP_START) begin
            sent_ctrl     = item.control_to_send;
            awaited_ctrl  = item.control_to_expect;
            attempt_count = 4'd0;
            link_active   = 1'b1;
            queue_frame();
            return 1'b1;
        end
        if (!link_active || item.op == OP_NONE)
            return 1'b0;
        if (item.op == OP_RXBYTE) begin
            // The match test wins over the flag test in the address and
            // control positions.
            case (match_pos)
                POS_OPEN: begin
                    if (b == cfg_flag) match_pos = POS_ADDR;
                end
                POS_ADDR: begin
                    if (b == cfg_addr) match_pos = POS_CTRL;
                    else if (b == cfg_flag) match_pos = POS_ADDR;
                    else match_pos = POS_OPEN;
                end
                POS_CTRL: begin
                    if (b == awaited_ctrl) match_pos = POS_CHECK;
                    else if (b == cfg_flag) match_pos = POS_ADDR;
                    else match_pos = POS_OPEN;
                end
                POS_CHECK: begin
                    if (b == (cfg_addr ^ awaited_ctrl)) match_pos = POS_CLOSE;
                    else match_pos = POS_OPEN;
                end
                POS_CLOSE: begin
                    if (b == cfg_flag) begin
                        link_active = 1'b0;
                        queue_result(KIND_OK, 8'd0, 1'b1);
                    end
                    match_pos = POS_OPEN;
                end
                default: begin
                    match_pos = POS_OPEN;
                end
            endcase
            return 1'b1;
        end
        // Time tick: count down, and on expiry either resend or give up.
        if (ticks_left > 16'd1) begin
            ticks_left = ticks_left - 16'd1;
            return 1'b1;
        end
        ticks_left = 16'd0;
        if (attempt_count < 4'd15)
            attempt_count = attempt_count + 4'd1;
        if (attempt_count >= cfg_max_att) begin
            link_active = 1'b0;
            match_pos   = POS_OPEN;
            queue_result(KIND_FAIL, 8'd0, 1'b1);
        end else begin
            queue_frame();
        end
        return 1'b1;
    endfunction

    // Sends one input transaction, with an occasional idle burst ahead of it.
    // Valid stays high afterward so that back-to-back events need no gap.
    task automatic send_event(t_op op, logic [7:0] data_byte, logic [7:0] ctrl_send,
                              logic [7:0] ctrl_expect);
        t_in_item item;
        item.op                = op;
        item.data_byte         = data_byte;
        item.control_to_send   = ctrl_send;
        item.control_to_expect = ctrl_expect;
        if (in_gaps_on && $urandom_range(1, gap_odds) == 1) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= item;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        if (predict_link(item))
            event_count++;
    endtask

    task automatic send_start(logic [7:0] ctrl_send, logic [7:0] ctrl_expect);
        send_event(OP_START, 8'($urandom_range(0, 255)), ctrl_send, ctrl_expect);
    endtask

    task automatic send_byte(logic [7:0] b);
        send_event(OP_RXBYTE, b, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    endtask

    task automatic send_tick();
        send_event(OP_TICK, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)));
    endtask

    // Sends the answer frame awaited now, optionally with one byte spoiled
    // and optionally behind a stray byte.
    task automatic send_answer(bit broken);
        logic [7:0] frame_bytes [0:4];
        int k;
        frame_bytes[0] = cfg_flag;
        frame_bytes[1] = cfg_addr;
        frame_bytes[2] = awaited_ctrl;
        frame_bytes[3] = cfg_addr ^ awaited_ctrl;
        frame_bytes[4] = cfg_flag;
        if (broken)
            frame_bytes[3'($urandom_range(0, 4))] = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 3) == 0)
            send_byte(8'($urandom_range(0, 255)));
        for (k = 0; k < 5; k++)
            send_byte(frame_bytes[k]);
    endtask

    // Stops input and waits until every predicted result has been seen, then
    // keeps waiting so that events that produce nothing are settled too.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // Writes one configuration register while the block is quiet.
    task automatic write_config(t_cfg_idx index, logic [15:0] value);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        case (index)
            CFG_FLAG:    cfg_flag    = value[7:0];
            CFG_ADDR:    cfg_addr    = value[7:0];
            CFG_MAXATT:  cfg_max_att = value[3:0];
            CFG_TIMEOUT: cfg_timeout = value;
            default: ;
        endcase
    endtask

    // Result checker and receiver stall generator.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual kind %0d byte %0h last %0d",
                         $time, o_out_item.kind, o_out_item.tx_byte, o_out_item.last);
                error_count++;
            end else begin
                oldest_result = expected_results.pop_front();
                if (o_out_item.kind !== oldest_result.kind) begin
                    $display("%0t: kind mismatch, expected %0d, actual %0d",
                             $time, oldest_result.kind, o_out_item.kind);
                    error_count++;
                end
                if (o_out_item.tx_byte !== oldest_result.tx_byte) begin
                    $display("%0t: tx_byte mismatch, expected %0h, actual %0h",
                             $time, oldest_result.tx_byte, o_out_item.tx_byte);
                    error_count++;
                end
                if (o_out_item.last !== oldest_result.last) begin
                    $display("%0t: last mismatch, expected %0d, actual %0d",
                             $time, oldest_result.last, o_out_item.last);
                    error_count++;
                end
            end
        end
        if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if (out_stalls_on && $urandom_range(1, 6) == 1) begin
            stall_left = $urandom_range(0, 17);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Received bytes and ticks while idle must produce nothing.
    task automatic test_idle_events();
        send_tick();
        send_byte(FLAG_RESET);
        drain_results();
    endtask

    // Flag restarts in the address and control positions, a bad check byte,
    // then a clean answer that reports success.
    task automatic test_answer_recognition();
        send_start(8'hA5, 8'h5A);
        send_byte(FLAG_RESET);
        send_byte(FLAG_RESET);
        send_byte(ADDR_RESET);
        send_byte(FLAG_RESET);
        send_byte(ADDR_RESET);
        send_byte(8'h5A);
        send_byte(8'h00);
        send_byte(FLAG_RESET);
        send_byte(ADDR_RESET);
        send_byte(8'h5A);
        send_byte(ADDR_RESET ^ 8'h5A);
        send_byte(8'h00);
        send_answer(1'b0);
        drain_results();
    endtask

    // Unknown op and restart while active, then timeouts up to failure.
    task automatic test_retries_and_restart();
        send_start(8'hFF, 8'h00);
        send_event(OP_NONE, 8'hFF, 8'hFF, 8'hFF);
        send_start(8'hFF, 8'h00);
        repeat (9) send_tick();
        drain_results();
    endtask

    // Register extremes, including the zero timeout and zero attempt cases.
    task automatic test_register_extremes();
        write_config(CFG_FLAG, 16'h00FF);
        write_config(CFG_ADDR, 16'h0000);
        write_config(CFG_MAXATT, 16'd15);
        write_config(CFG_TIMEOUT, 16'hFFFF);
        send_start(8'h00, 8'hFF);
        send_answer(1'b0);
        write_config(CFG_FLAG, 16'h0000);
        write_config(CFG_ADDR, 16'h00FF);
        write_config(CFG_MAXATT, 16'd0);
        write_config(CFG_TIMEOUT, 16'd0);
        send_start(8'h3C, 8'hC3);
        send_tick();
        write_config(CFG_MAXATT, 16'd2);
        send_start(8'h81, 8'h18);
        send_tick();
        send_tick();
        drain_results();
    endtask

    // Phases of random traffic, each under its own register settings. Most
    // events are answer frames, a quarter of them spoiled; the rest are starts,
    // ticks and noise. The final stretch runs without idling on either side.
    task automatic test_random_traffic();
        int first_count;
        int phase_end;
        int choice;
        first_count = event_count;
        while (event_count - first_count < 250) begin
            write_config(CFG_FLAG, 16'($urandom_range(0, 255)));
            write_config(CFG_ADDR, 16'($urandom_range(0, 255)));
            write_config(CFG_MAXATT, 16'($urandom_range(0, 15)));
            write_config(CFG_TIMEOUT, ($urandom_range(0, 7) == 0) ? 16'd0
                                                                  : 16'($urandom_range(1, 5)));
            if (event_count - first_count > 200) begin
                in_gaps_on    = 1'b0;
                out_stalls_on = 1'b0;
            end else begin
                in_gaps_on    = ($urandom_range(0, 3) != 0);
                out_stalls_on = ($urandom_range(0, 3) != 0);
                gap_odds      = $urandom_range(2, 8);
            end
            phase_end = event_count + $urandom_range(20, 50);
            while (event_count < phase_end) begin
                choice = $urandom_range(0, 9);
                if ((!link_active && choice < 8) || choice == 0)
                    send_start(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
                else if (choice <= 4)
                    send_answer($urandom_range(0, 3) == 0);
                else if (choice <= 7)
                    send_tick();
                else
                    send_event(t_op'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                               8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            end
        end
    endtask

    // Test sequence.
    initial begin
        i_rst_n       <= 1'b0;
        i_in_valid    <= 1'b0;
        i_in_item     <= '0;
        i_out_stall   <= 1'b0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= '0;
        i_cfg_data    <= '0;
        cfg_flag      = FLAG_RESET;
        cfg_addr      = ADDR_RESET;
        cfg_max_att   = MAXATT_RESET;
        cfg_timeout   = TIMEOUT_RESET;
        link_active   = 1'b0;
        match_pos     = POS_OPEN;
        attempt_count = 4'd0;
        ticks_left    = 16'd0;
        sent_ctrl     = 8'd0;
        awaited_ctrl  = 8'd0;
        error_count   = 0;
        event_count   = 0;
        stall_left    = 0;
        gap_odds      = 4;
        in_gaps_on    = 1'b1;
        out_stalls_on = 1'b1;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_idle_events();
        test_answer_recognition();
        test_retries_and_restart();
        test_register_extremes();
        test_random_traffic();

        drain_results();
        repeat (10) @(posedge i_clk);
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule : stop_and_wait_supervision_link_test
`default_nettype wire

FILE: stop_and_wait_supervision_link.f
rtl/swsl_pkg.sv
rtl/swsl_front.sv
rtl/swsl_cmd_fifo.sv
rtl/swsl_back.sv
rtl/stop_and_wait_supervision_link.sv
test/stop_and_wait_supervision_link_test.sv
